// File: design/svp_pkg.sv
// Shared types and constants of the stepper valve positioner.
package svp_pkg;

	localparam logic [1:0] OP_TICK      = 2'd0;
	localparam logic [1:0] OP_TARGET    = 2'd1;
	localparam logic [1:0] OP_HOME      = 2'd2;
	localparam logic [1:0] OP_EMERGENCY = 2'd3;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_TRAVEL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_INTERVAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAVE_DEBOUNCE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOMING_EXTRA  = 3'd4;

	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [15:0] DEFAULT_TRAVEL       = 16'd480;
	localparam logic [15:0] RST_STEP_INTERVAL    = 16'd20;
	localparam logic [15:0] RST_FAST_INTERVAL    = 16'd10;
	localparam logic [31:0] RST_SAVE_DEBOUNCE    = 32'd60000;
	localparam logic [15:0] RST_HOMING_EXTRA     = 16'd50;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] elapsed_ms;
		logic [15:0] target_steps;
		logic        step_ok;
	} svp_in_t;

	typedef struct packed {
		logic        step_pulse;
		logic        step_direction;
		logic [15:0] position;
		logic [15:0] goal_out;
		logic        calibrated;
		logic        homing_busy;
		logic        save_request;
		logic        command_accepted;
	} svp_out_t;

	typedef struct packed {
		logic [15:0] full_travel;
		logic [15:0] step_period_ms;
		logic [15:0] fast_interval_ms;
		logic [31:0] save_debounce_ms;
		logic [15:0] home_overrun;
	} svp_cfg_t;

	typedef struct packed {
		logic [15:0] position_steps;
		logic [15:0] goal_position;
		logic        is_calibrated;
		logic        homing_active;
		logic [16:0] homing_left;
		logic [31:0] step_accum_ms;
		logic        fast_close;
		logic        save_pending;
		logic [31:0] settle_ms;
		logic        direction_line;
	} svp_state_t;

endpackage

// File: design/stepper_valve_positioner_unit.sv
// Top level of the stepper valve positioner: input and result registers around the core.
// A command is held in the input register, evaluated by the core and its result is
// loaded into the result register on advance, from which it leaves when not stalled.
// Throughput: one transaction per cycle unless out_stall holds the result register;
// the update is combinational add, compare and subtract logic between the two registers.
// Reset (arst_n low, asynchronous): position and goal zero, uncalibrated,
// both stages empty, configuration at 480, 20, 10, 60000 and 50.
module stepper_valve_positioner_unit
	import svp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  svp_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output svp_out_t              out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	svp_cfg_t cfg;
	svp_in_t  item_s1;
	logic     valid_s1;
	svp_out_t result;
	svp_out_t result_s2;
	logic     valid_s2;
	logic     advance;

	// Advance the held command into the result register whenever that
	// register is empty or its transaction leaves at this edge.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	// Take a new command while stage one is empty or moving on.
	assign in_stall = valid_s1 && !advance;

	svp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register: hold the command until the core consumes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// The core commits its state only on advance, so a stalled command is
	// evaluated again against unchanged state and gives the same result.
	svp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result register: drop the transaction once taken, load the next on advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule

// File: design/svp_cfg_regs.sv
// Configuration register file of the stepper valve positioner.
module svp_cfg_regs
	import svp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output svp_cfg_t              cfg
);

	svp_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_travel        <= DEFAULT_TRAVEL;
			cfg_q.step_period_ms     <= RST_STEP_INTERVAL;
			cfg_q.fast_interval_ms   <= RST_FAST_INTERVAL;
			cfg_q.save_debounce_ms   <= RST_SAVE_DEBOUNCE;
			cfg_q.home_overrun       <= RST_HOMING_EXTRA;
		end else if (cfg_we) begin
			// indexes past the list are dropped
			case (cfg_index)
				REG_FULL_TRAVEL:   cfg_q.full_travel        <= cfg_data[15:0];
				REG_STEP_INTERVAL: cfg_q.step_period_ms     <= cfg_data[15:0];
				REG_FAST_INTERVAL: cfg_q.fast_interval_ms   <= cfg_data[15:0];
				REG_SAVE_DEBOUNCE: cfg_q.save_debounce_ms   <= cfg_data;
				REG_HOMING_EXTRA:  cfg_q.home_overrun       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/svp_core.sv
// Motion state registers and per-command update logic of the valve positioner.
module svp_core
	import svp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     advance,
	input  svp_in_t  item,
	input  svp_cfg_t cfg,
	output svp_out_t result
);

	svp_state_t st_q;
	svp_state_t nxt;

	logic [15:0] travel;
	logic [32:0] accum_sum;
	logic [31:0] accum_sat;
	logic [32:0] settle_sum;
	logic [31:0] settle_sat;
	logic [15:0] interval;
	logic        opening;
	logic [15:0] pos_next;
	logic        pulse;
	logic        save;
	logic        accepted;

	always_comb begin
		travel     = (cfg.full_travel == 16'd0) ? DEFAULT_TRAVEL : cfg.full_travel;
		accum_sum  = {1'b0, st_q.step_accum_ms} + {17'd0, item.elapsed_ms};
		accum_sat  = accum_sum[32] ? 32'hFFFF_FFFF : accum_sum[31:0];
		settle_sum = {1'b0, st_q.settle_ms} + {17'd0, item.elapsed_ms};
		settle_sat = settle_sum[32] ? 32'hFFFF_FFFF : settle_sum[31:0];
		interval   = st_q.fast_close ? cfg.fast_interval_ms : cfg.step_period_ms;
		opening    = st_q.goal_position > st_q.position_steps;
		if (opening) begin
			pos_next = st_q.position_steps + 16'd1;
		end else if (st_q.position_steps != 16'd0) begin
			pos_next = st_q.position_steps - 16'd1;
		end else begin
			pos_next = st_q.position_steps;
		end

		nxt      = st_q;
		pulse    = 1'b0;
		save     = 1'b0;
		accepted = 1'b0;

		unique case (item.op)
			OP_TARGET: begin
				if (st_q.is_calibrated) begin
					nxt.goal_position = (item.target_steps > travel) ? travel
						: item.target_steps;
					accepted = 1'b1;
				end
			end
			OP_HOME: begin
				nxt.homing_left   = {1'b0, travel} + {1'b0, cfg.home_overrun};
				nxt.homing_active = 1'b1;
				nxt.step_accum_ms = 32'd0;
				accepted          = 1'b1;
			end
			OP_EMERGENCY: begin
				nxt.goal_position = 16'd0;
				nxt.fast_close    = 1'b1;
				nxt.step_accum_ms = 32'd0;
			end
			OP_TICK: begin
				priority if (st_q.homing_active) begin
					nxt.step_accum_ms = accum_sat;
					if (accum_sat >= {16'd0, cfg.step_period_ms}) begin
						nxt.step_accum_ms = accum_sat - {16'd0, cfg.step_period_ms};
						if (st_q.homing_left != 17'd0) begin
							nxt.direction_line = 1'b0;
							pulse              = 1'b1;
							if (item.step_ok) begin
								nxt.homing_left = st_q.homing_left - 17'd1;
							end
						end else begin
							// closing run done: valve sits on the stop
							nxt.position_steps = 16'd0;
							nxt.goal_position  = 16'd0;
							nxt.is_calibrated  = 1'b1;
							nxt.homing_active  = 1'b0;
							save               = 1'b1;
						end
					end
				end else if (st_q.position_steps == st_q.goal_position) begin
					if (st_q.save_pending) begin
						nxt.settle_ms = settle_sat;
						if (settle_sat >= cfg.save_debounce_ms) begin
							save             = 1'b1;
							nxt.save_pending = 1'b0;
						end
					end
				end else begin
					nxt.step_accum_ms = accum_sat;
					if (accum_sat >= {16'd0, interval}) begin
						nxt.step_accum_ms  = accum_sat - {16'd0, interval};
						nxt.direction_line = opening;
						pulse              = 1'b1;
						if (item.step_ok) begin
							nxt.position_steps = pos_next;
							if (pos_next == st_q.goal_position) begin
								nxt.fast_close   = 1'b0;
								nxt.save_pending = 1'b1;
								nxt.settle_ms    = 32'd0;
							end
						end
					end
				end
			end
		endcase

		result.step_pulse       = pulse;
		result.step_direction   = nxt.direction_line;
		result.position         = nxt.position_steps;
		result.goal_out         = nxt.goal_position;
		result.calibrated       = nxt.is_calibrated;
		result.homing_busy      = nxt.homing_active;
		result.save_request     = save;
		result.command_accepted = accepted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= nxt;
		end
	end

endmodule
